// ===== src/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// psu_pkg: shared types and constants of the particle swarm update engine
// Payload structs, sequencer codes, register indexes and helper functions.
// ----------------------------------------------------------------------------
package psu_pkg;

  localparam int NUM_PARTICLES_DEF = 16;
  localparam int WORD_W            = 16;
  localparam int FIT_W             = 17;
  localparam int IDX_W             = 4;
  localparam int CFG_IDX_W         = 3;
  localparam int MUL_W             = 18;
  localparam int PROD_W            = 2 * MUL_W;
  localparam int ACC_W             = 24;
  localparam int FRAC_SH           = 12;
  localparam int RC_SH             = 16;

  localparam logic [FIT_W-1:0] FIT_ALL_ONES = '1;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_UPDATE = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INERTIA   = 3'd0,
    CFG_COGNITIVE = 3'd1,
    CFG_SOCIAL    = 3'd2,
    CFG_POS_MIN   = 3'd3,
    CFG_POS_MAX   = 3'd4,
    CFG_SPEED_MAX = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MS_RC1      = 3'd0,
    MS_RC2      = 3'd1,
    MS_INERTIA  = 3'd2,
    MS_COG      = 3'd3,
    MS_SOC      = 3'd4
  } mul_step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_CLAMP_V,
    ST_CLAMP_X,
    ST_FIT,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    opcode_t                  opcode;
    logic [IDX_W-1:0]         particle;
    logic signed [WORD_W-1:0] load_pos_x;
    logic signed [WORD_W-1:0] load_pos_y;
    logic signed [WORD_W-1:0] load_vel_x;
    logic signed [WORD_W-1:0] load_vel_y;
    logic [WORD_W-1:0]        rand_pb_x;
    logic [WORD_W-1:0]        rand_gb_x;
    logic [WORD_W-1:0]        rand_pb_y;
    logic [WORD_W-1:0]        rand_gb_y;
    logic                     end_of_sweep;
  } psu_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]         particle_out;
    logic signed [WORD_W-1:0] new_x;
    logic signed [WORD_W-1:0] new_y;
    logic [FIT_W-1:0]         fitness;
    logic signed [WORD_W-1:0] swarm_best_x;
    logic signed [WORD_W-1:0] swarm_best_y;
    logic                     converged;
  } psu_out_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] pos_x;
    logic signed [WORD_W-1:0] pos_y;
    logic signed [WORD_W-1:0] vel_x;
    logic signed [WORD_W-1:0] vel_y;
    logic signed [WORD_W-1:0] best_x;
    logic signed [WORD_W-1:0] best_y;
  } particle_rec_t;

  function automatic logic [FIT_W-1:0] psu_abs(input logic signed [WORD_W-1:0] v);
    logic [FIT_W-1:0] e;
    e = {v[WORD_W-1], v};
    return v[WORD_W-1] ? (FIT_W'(0) - e) : e;
  endfunction

  // index reduced modulo the swarm size; at most seven subtractions for n >= 2
  function automatic logic [IDX_W-1:0] psu_wrap(input logic [IDX_W-1:0] idx,
                                                input int n);
    logic [IDX_W-1:0] r;
    r = idx;
    for (int i = 0; i < 8; i++) begin
      if (int'(r) >= n) begin
        r = r - IDX_W'(n);
      end
    end
    return r;
  endfunction

  function automatic logic psu_near_zero(input logic signed [WORD_W-1:0] bx,
                                         input logic signed [WORD_W-1:0] by);
    return (bx > -16'sd256) && (bx < 16'sd256) && (by > -16'sd256) && (by < 16'sd256);
  endfunction

endpackage

// ===== src/psu_chan_if.sv =====
// ----------------------------------------------------------------------------
// psu_chan_if: valid/ready channel
// Carries one payload per transfer; source drives valid and data.
// ----------------------------------------------------------------------------
interface psu_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/psu_ram.sv =====
// ----------------------------------------------------------------------------
// psu_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/particle_swarm_update.sv =====
// ----------------------------------------------------------------------------
// particle_swarm_update: 2-D fixed-point particle swarm engine, global best
// Load: the item passes the fit and commit states to the result. Update:
// ten products on one shared 18x18 multiplier, a drain and the velocity and
// position clamp states per axis, then fitness and commit. One item in flight:
// a new item is taken only in idle; commit waits while a result is held.
// Synchronous reset clears control and swarm registers and loads config defaults, not the RAM.
// ----------------------------------------------------------------------------
module particle_swarm_update #(
  parameter int NUM_PARTICLES = psu_pkg::NUM_PARTICLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  psu_chan_if.sink                       items,
  psu_chan_if.source                     results,
  input  logic                           cfg_en,
  input  logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psu_pkg::WORD_W-1:0]     cfg_data
);
  localparam int PIDX_W = $clog2(NUM_PARTICLES);
  localparam int W      = psu_pkg::WORD_W;
  localparam int REC_W  = $bits(psu_pkg::particle_rec_t);

  psu_pkg::state_t state, state_next;

  // configuration
  logic [W-1:0]        inertia;
  logic [W-1:0]        cognitive_gain;
  logic [W-1:0]        social_gain;
  logic signed [W-1:0] pos_min;
  logic signed [W-1:0] pos_max;
  logic [W-2:0]        speed_max;

  // swarm state
  logic signed [W-1:0]             gbest_x, gbest_y;
  logic signed [W-1:0]             lead_x, lead_y;
  logic [psu_pkg::FIT_W-1:0]       sweep_min;

  // item work registers
  psu_pkg::psu_in_t                item;
  logic [psu_pkg::IDX_W-1:0]       p_reg;
  psu_pkg::mul_step_t              step;
  logic                            axis;
  logic signed [psu_pkg::PROD_W-1:0] prod;
  psu_pkg::mul_step_t              prod_tag;
  logic                            prod_vld;
  logic [W-1:0]                    rc1, rc2;
  logic signed [psu_pkg::ACC_W-1:0] acc;
  logic signed [W-1:0]             v_cl;
  logic signed [W-1:0]             nx, ny, nvx, nvy;
  logic [psu_pkg::FIT_W-1:0]       fit, pfit;

  psu_pkg::psu_out_t               res;
  logic                            res_vld;

  // RAM
  psu_pkg::particle_rec_t          rec, rec_wr;
  logic [REC_W-1:0]                rd_raw;
  logic [PIDX_W-1:0]               rd_addr;
  logic                            ram_we;

  // control
  logic                            accept;
  logic                            commit_go;
  logic signed [psu_pkg::MUL_W-1:0] mul_a, mul_b;

  // datapath views
  logic signed [W-1:0]             x_cur, v_cur, b_cur, g_cur;
  logic [W-1:0]                    r_pb, r_gb;
  logic signed [W:0]               diff_pb, diff_gb;
  logic signed [psu_pkg::ACC_W-1:0] lim, neg_lim;
  logic signed [psu_pkg::ACC_W-1:0] prod_sh;
  logic signed [W:0]               x_sum, hi_e, lo_e;
  logic signed [W-1:0]             best_sel_x, best_sel_y;
  logic signed [W-1:0]             lead_nx, lead_ny, gb_nx, gb_ny;

  assign rec = psu_pkg::particle_rec_t'(rd_raw);

  psu_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_PARTICLES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (PIDX_W'(p_reg)),
    .wdata (REC_W'(rec_wr)),
    .raddr (rd_addr),
    .rdata (rd_raw)
  );

  assign rd_addr = (state == psu_pkg::ST_IDLE)
                 ? PIDX_W'(psu_pkg::psu_wrap(items.data.particle, NUM_PARTICLES))
                 : PIDX_W'(p_reg);

  // per-axis operands
  always_comb begin
    x_cur   = axis ? rec.pos_y : rec.pos_x;
    v_cur   = axis ? rec.vel_y : rec.vel_x;
    b_cur   = axis ? rec.best_y : rec.best_x;
    g_cur   = axis ? gbest_y : gbest_x;
    r_pb    = axis ? item.rand_pb_y : item.rand_pb_x;
    r_gb    = axis ? item.rand_gb_y : item.rand_gb_x;
    diff_pb = {b_cur[W-1], b_cur} - {x_cur[W-1], x_cur};
    diff_gb = {g_cur[W-1], g_cur} - {x_cur[W-1], x_cur};
    lim     = psu_pkg::ACC_W'({1'b0, speed_max});
    neg_lim = -lim;
    prod_sh = prod[psu_pkg::PROD_W-1:psu_pkg::FRAC_SH];
    x_sum   = {x_cur[W-1], x_cur} + {v_cl[W-1], v_cl};
    hi_e    = {pos_max[W-1], pos_max};
    lo_e    = {pos_min[W-1], pos_min};
  end

  // personal best and sweep lead for this item
  always_comb begin
    if (item.opcode == psu_pkg::OP_LOAD || pfit > fit) begin
      best_sel_x = nx;
      best_sel_y = ny;
    end else begin
      best_sel_x = rec.best_x;
      best_sel_y = rec.best_y;
    end
    if (fit < sweep_min) begin
      lead_nx = best_sel_x;
      lead_ny = best_sel_y;
    end else begin
      lead_nx = lead_x;
      lead_ny = lead_y;
    end
    gb_nx = item.end_of_sweep ? lead_nx : gbest_x;
    gb_ny = item.end_of_sweep ? lead_ny : gbest_y;
    rec_wr.pos_x  = nx;
    rec_wr.pos_y  = ny;
    rec_wr.vel_x  = nvx;
    rec_wr.vel_y  = nvy;
    rec_wr.best_x = best_sel_x;
    rec_wr.best_y = best_sel_y;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      psu_pkg::ST_IDLE: begin
        if (items.valid) begin
          state_next = (items.data.opcode == psu_pkg::OP_LOAD)
                     ? psu_pkg::ST_FIT : psu_pkg::ST_ISSUE;
        end
      end
      psu_pkg::ST_ISSUE: begin
        if (step == psu_pkg::MS_SOC) begin
          state_next = psu_pkg::ST_DRAIN;
        end
      end
      psu_pkg::ST_DRAIN:   state_next = psu_pkg::ST_CLAMP_V;
      psu_pkg::ST_CLAMP_V: state_next = psu_pkg::ST_CLAMP_X;
      psu_pkg::ST_CLAMP_X: state_next = axis ? psu_pkg::ST_FIT : psu_pkg::ST_ISSUE;
      psu_pkg::ST_FIT:     state_next = psu_pkg::ST_COMMIT;
      psu_pkg::ST_COMMIT: begin
        if (commit_go) begin
          state_next = psu_pkg::ST_IDLE;
        end
      end
      default: state_next = psu_pkg::ST_IDLE;
    endcase
  end

  // control outputs and multiplier operands
  always_comb begin
    items.ready = (state == psu_pkg::ST_IDLE);
    accept      = items.valid && items.ready;
    commit_go   = (state == psu_pkg::ST_COMMIT) && !(res_vld && !results.ready);
    ram_we      = commit_go;
    mul_a       = '0;
    mul_b       = '0;
    case (step)
      psu_pkg::MS_RC1: begin
        mul_a = psu_pkg::MUL_W'(r_pb);
        mul_b = psu_pkg::MUL_W'(cognitive_gain);
      end
      psu_pkg::MS_RC2: begin
        mul_a = psu_pkg::MUL_W'(r_gb);
        mul_b = psu_pkg::MUL_W'(social_gain);
      end
      psu_pkg::MS_INERTIA: begin
        mul_a = psu_pkg::MUL_W'(inertia);
        mul_b = psu_pkg::MUL_W'(v_cur);
      end
      psu_pkg::MS_COG: begin
        mul_a = psu_pkg::MUL_W'(rc1);
        mul_b = psu_pkg::MUL_W'(diff_pb);
      end
      psu_pkg::MS_SOC: begin
        mul_a = psu_pkg::MUL_W'(rc2);
        mul_b = psu_pkg::MUL_W'(diff_gb);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign results.valid = res_vld;
  assign results.data  = res;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      inertia        <= 16'd4096;
      cognitive_gain <= 16'd8192;
      social_gain    <= 16'd8192;
      pos_min        <= -16'sd25600;
      pos_max        <= 16'sd25600;
      speed_max      <= 15'd25600;
    end else if (cfg_en) begin
      unique case (psu_pkg::cfg_idx_t'(cfg_index))
        psu_pkg::CFG_INERTIA:   inertia        <= cfg_data;
        psu_pkg::CFG_COGNITIVE: cognitive_gain <= cfg_data;
        psu_pkg::CFG_SOCIAL:    social_gain    <= cfg_data;
        psu_pkg::CFG_POS_MIN:   pos_min        <= cfg_data;
        psu_pkg::CFG_POS_MAX:   pos_max        <= cfg_data;
        psu_pkg::CFG_SPEED_MAX: speed_max      <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= psu_pkg::ST_IDLE;
      step      <= psu_pkg::MS_RC1;
      axis      <= 1'b0;
      prod_vld  <= 1'b0;
      res_vld   <= 1'b0;
      gbest_x   <= '0;
      gbest_y   <= '0;
      lead_x    <= '0;
      lead_y    <= '0;
      sweep_min <= psu_pkg::FIT_ALL_ONES;
    end else begin
      state    <= state_next;
      prod_vld <= (state == psu_pkg::ST_ISSUE);
      if (accept) begin
        step <= psu_pkg::MS_RC1;
        axis <= 1'b0;
      end else if (state == psu_pkg::ST_ISSUE && step != psu_pkg::MS_SOC) begin
        step <= psu_pkg::mul_step_t'(step + 3'd1);
      end else if (state == psu_pkg::ST_CLAMP_X) begin
        step <= psu_pkg::MS_RC1;
        axis <= 1'b1;
      end
      if (commit_go) begin
        res_vld <= 1'b1;
      end else if (results.ready) begin
        res_vld <= 1'b0;
      end
      if (commit_go) begin
        lead_x <= lead_nx;
        lead_y <= lead_ny;
        if (item.end_of_sweep) begin
          gbest_x   <= lead_nx;
          gbest_y   <= lead_ny;
          sweep_min <= psu_pkg::FIT_ALL_ONES;
        end else if (fit < sweep_min) begin
          sweep_min <= fit;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod     <= mul_a * mul_b;
    prod_tag <= step;
    if (accept) begin
      item  <= items.data;
      p_reg <= psu_pkg::psu_wrap(items.data.particle, NUM_PARTICLES);
      nx    <= items.data.load_pos_x;
      ny    <= items.data.load_pos_y;
      nvx   <= items.data.load_vel_x;
      nvy   <= items.data.load_vel_y;
    end
    if (prod_vld) begin
      case (prod_tag)
        psu_pkg::MS_RC1:     rc1 <= prod[psu_pkg::RC_SH+W-1:psu_pkg::RC_SH];
        psu_pkg::MS_RC2:     rc2 <= prod[psu_pkg::RC_SH+W-1:psu_pkg::RC_SH];
        psu_pkg::MS_INERTIA: acc <= prod_sh;
        default:             acc <= acc + prod_sh;
      endcase
    end
    if (state == psu_pkg::ST_CLAMP_V) begin
      if (acc < neg_lim) begin
        v_cl <= W'(neg_lim);
      end else if (acc > lim) begin
        v_cl <= W'(lim);
      end else begin
        v_cl <= W'(acc);
      end
    end
    if (state == psu_pkg::ST_CLAMP_X) begin
      if (axis) begin
        nvy <= v_cl;
        ny  <= (x_sum > hi_e) ? pos_max : (x_sum < lo_e) ? pos_min : W'(x_sum);
      end else begin
        nvx <= v_cl;
        nx  <= (x_sum > hi_e) ? pos_max : (x_sum < lo_e) ? pos_min : W'(x_sum);
      end
    end
    if (state == psu_pkg::ST_FIT) begin
      fit  <= psu_pkg::psu_abs(nx) + psu_pkg::psu_abs(ny);
      pfit <= psu_pkg::psu_abs(rec.best_x) + psu_pkg::psu_abs(rec.best_y);
    end
    if (commit_go) begin
      res.particle_out <= p_reg;
      res.new_x        <= nx;
      res.new_y        <= ny;
      res.fitness      <= fit;
      res.swarm_best_x <= gb_nx;
      res.swarm_best_y <= gb_ny;
      res.converged    <= psu_pkg::psu_near_zero(gb_nx, gb_ny);
    end
  end
endmodule

// ===== src/psu_checker.sv =====
// ----------------------------------------------------------------------------
// psu_checker: port-level checks of the particle swarm update engine
// Watches the item and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module psu_checker (
  input logic              clk,
  input logic              rst,
  input logic              items_valid,
  input logic              items_ready,
  input logic              results_valid,
  input logic              results_ready,
  input psu_pkg::psu_out_t results_data
);
  // one item at a time: busy right after an input transfer
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    items_valid && items_ready |=> !items_ready)
    else $error("ready high right after an input transfer");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    results_valid && !results_ready |=> results_valid && $stable(results_data))
    else $error("stalled result changed");

  a_fitness: assert property (@(posedge clk) disable iff (rst)
    results_valid |-> results_data.fitness ==
      psu_pkg::psu_abs(results_data.new_x) + psu_pkg::psu_abs(results_data.new_y))
    else $error("fitness does not match position");

  a_converged: assert property (@(posedge clk) disable iff (rst)
    results_valid |-> results_data.converged ==
      psu_pkg::psu_near_zero(results_data.swarm_best_x, results_data.swarm_best_y))
    else $error("converged flag does not match global best");
endmodule

bind particle_swarm_update psu_checker u_psu_checker (
  .clk           (clk),
  .rst           (rst),
  .items_valid   (items.valid),
  .items_ready   (items.ready),
  .results_valid (results.valid),
  .results_ready (results.ready),
  .results_data  (results.data)
);

// ===== tb/particle_swarm_update_test.sv =====
// ----------------------------------------------------------------------------
// particle_swarm_update_test: self-checking bench for the swarm update engine
// Loads and updates particles in sweeps under several gain, range and speed
// settings, predicts every result in fixed point and compares field by field.
// ----------------------------------------------------------------------------
module particle_swarm_update_test;
  import psu_pkg::*;

  localparam int SWARM_SIZE = 16;
  localparam int IDLE_LIMIT = 1000;
  localparam int PHASE_ITEMS = 92;
  localparam int NUM_PHASES = 8;

  logic clk;
  logic rst;
  logic cfg_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0] cfg_data;

  psu_chan_if #(.payload_t(psu_in_t)) items_if ();
  psu_chan_if #(.payload_t(psu_out_t)) results_if ();

  particle_swarm_update #(.NUM_PARTICLES(SWARM_SIZE)) dut (
    .clk(clk),
    .rst(rst),
    .items(items_if),
    .results(results_if),
    .cfg_en(cfg_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  class swarm_scoreboard;
    logic signed [15:0] pos_x[SWARM_SIZE], pos_y[SWARM_SIZE];
    logic signed [15:0] vel_x[SWARM_SIZE], vel_y[SWARM_SIZE];
    logic signed [15:0] best_x[SWARM_SIZE], best_y[SWARM_SIZE];
    logic signed [15:0] gbest_x, gbest_y, lead_x, lead_y;
    logic [16:0] min_fit;
    logic [15:0] inertia, cog_gain, soc_gain;
    logic signed [15:0] pos_lo, pos_hi;
    logic [14:0] speed_lim;
    psu_out_t expected_results[$];
    int mismatches;

    function new();
      gbest_x = '0;
      gbest_y = '0;
      lead_x = '0;
      lead_y = '0;
      min_fit = '1;
      inertia = 16'd4096;
      cog_gain = 16'd8192;
      soc_gain = 16'd8192;
      pos_lo = -16'sd25600;
      pos_hi = 16'sd25600;
      speed_lim = 15'd25600;
      mismatches = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [15:0] d);
      case (idx)
        CFG_INERTIA: inertia = d;
        CFG_COGNITIVE: cog_gain = d;
        CFG_SOCIAL: soc_gain = d;
        CFG_POS_MIN: pos_lo = d;
        CFG_POS_MAX: pos_hi = d;
        CFG_SPEED_MAX: speed_lim = d[14:0];
        default: ;
      endcase
    endfunction

    function logic [16:0] magnitude(logic signed [15:0] v);
      longint t;
      t = v;
      if (t < 0) t = -t;
      return t[16:0];
    endfunction

    function void advance_axis(input logic signed [15:0] x, v, best, gb,
                               input logic [15:0] r1, r2,
                               output logic signed [15:0] nx, nv);
      longint xl, rc1, rc2, acc, lim;
      xl = x;
      rc1 = (longint'(r1) * longint'(cog_gain)) >>> 16;
      rc2 = (longint'(r2) * longint'(soc_gain)) >>> 16;
      acc = ((longint'(inertia) * longint'(v)) >>> 12)
          + ((rc1 * (longint'(best) - xl)) >>> 12)
          + ((rc2 * (longint'(gb) - xl)) >>> 12);
      lim = longint'(speed_lim);
      if (acc < -lim) acc = -lim;
      else if (acc > lim) acc = lim;
      xl = xl + acc;
      // inverted range: the upper bound wins above it, the lower bound otherwise
      if (xl > longint'(pos_hi)) xl = pos_hi;
      else if (xl < longint'(pos_lo)) xl = pos_lo;
      nx = xl[15:0];
      nv = acc[15:0];
    endfunction

    function void note_item(psu_in_t it);
      int p;
      logic signed [15:0] nx, ny, nvx, nvy;
      logic [16:0] fit, pfit;
      psu_out_t r;
      p = int'(it.particle) % SWARM_SIZE;
      if (it.opcode == OP_LOAD) begin
        pos_x[p] = it.load_pos_x;
        pos_y[p] = it.load_pos_y;
        vel_x[p] = it.load_vel_x;
        vel_y[p] = it.load_vel_y;
        best_x[p] = it.load_pos_x;
        best_y[p] = it.load_pos_y;
      end else begin
        advance_axis(pos_x[p], vel_x[p], best_x[p], gbest_x, it.rand_pb_x, it.rand_gb_x,
                     nx, nvx);
        advance_axis(pos_y[p], vel_y[p], best_y[p], gbest_y, it.rand_pb_y, it.rand_gb_y,
                     ny, nvy);
        pos_x[p] = nx;
        pos_y[p] = ny;
        vel_x[p] = nvx;
        vel_y[p] = nvy;
        pfit = magnitude(best_x[p]) + magnitude(best_y[p]);
        if (pfit > magnitude(nx) + magnitude(ny)) begin
          best_x[p] = nx;
          best_y[p] = ny;
        end
      end
      fit = magnitude(pos_x[p]) + magnitude(pos_y[p]);
      if (fit < min_fit) begin
        min_fit = fit;
        lead_x = best_x[p];
        lead_y = best_y[p];
      end
      if (it.end_of_sweep) begin
        gbest_x = lead_x;
        gbest_y = lead_y;
        min_fit = '1;
      end
      r.particle_out = 4'(p);
      r.new_x = pos_x[p];
      r.new_y = pos_y[p];
      r.fitness = fit;
      r.swarm_best_x = gbest_x;
      r.swarm_best_y = gbest_y;
      r.converged = (magnitude(gbest_x) < 17'd256) && (magnitude(gbest_y) < 17'd256);
      expected_results.push_back(r);
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic [16:0] got, logic [16:0] want);
      if (got !== want) report($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task check_result(psu_out_t got);
      psu_out_t want;
      if (expected_results.size() == 0) begin
        report("result transfer with nothing expected");
        return;
      end
      want = expected_results.pop_front();
      compare_field("particle_out", got.particle_out, want.particle_out);
      compare_field("new_x", got.new_x, want.new_x);
      compare_field("new_y", got.new_y, want.new_y);
      compare_field("fitness", got.fitness, want.fitness);
      compare_field("swarm_best_x", got.swarm_best_x, want.swarm_best_x);
      compare_field("swarm_best_y", got.swarm_best_y, want.swarm_best_y);
      compare_field("converged", got.converged, want.converged);
    endtask

    function int pending();
      return expected_results.size();
    endfunction

    task flush_leftover();
      while (expected_results.size() != 0) begin
        report($sformatf("result for particle %0d never arrived",
                         expected_results[0].particle_out));
        void'(expected_results.pop_front());
      end
    endtask
  endclass

  swarm_scoreboard sb;
  bit quiet;
  bit loaded[SWARM_SIZE];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic psu_in_t make_item(opcode_t op, logic [3:0] p, logic eos);
    psu_in_t it;
    it.opcode = op;
    it.particle = p;
    it.load_pos_x = pick_word();
    it.load_pos_y = pick_word();
    it.load_vel_x = pick_word();
    it.load_vel_y = pick_word();
    it.rand_pb_x = pick_word();
    it.rand_gb_x = pick_word();
    it.rand_pb_y = pick_word();
    it.rand_gb_y = pick_word();
    it.end_of_sweep = eos;
    return it;
  endfunction

  task automatic send_item(psu_in_t it);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      items_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    items_if.valid <= 1'b1;
    items_if.data <= it;
    do @(posedge clk); while (!items_if.ready);
    sb.note_item(it);
    if (it.opcode == OP_LOAD) loaded[int'(it.particle) % SWARM_SIZE] = 1'b1;
    @(negedge clk);
  endtask

  task automatic load_at(logic [3:0] p, logic [15:0] x, y, vx, vy, logic eos);
    psu_in_t it;
    it = make_item(OP_LOAD, p, eos);
    it.load_pos_x = x;
    it.load_pos_y = y;
    it.load_vel_x = vx;
    it.load_vel_y = vy;
    send_item(it);
  endtask

  task automatic update_at(logic [3:0] p, logic [15:0] r, logic eos);
    psu_in_t it;
    it = make_item(OP_UPDATE, p, eos);
    it.rand_pb_x = r;
    it.rand_gb_x = r;
    it.rand_pb_y = r;
    it.rand_gb_y = r;
    send_item(it);
  endtask

  task automatic wait_idle();
    items_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [15:0] d);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    sb.set_register(idx, d);
    @(negedge clk);
  endtask

  task automatic configure(logic [15:0] w, c1, c2, lo, hi, spd);
    write_register(CFG_INERTIA, w);
    write_register(CFG_COGNITIVE, c1);
    write_register(CFG_SOCIAL, c2);
    write_register(CFG_POS_MIN, lo);
    write_register(CFG_POS_MAX, hi);
    write_register(CFG_SPEED_MAX, spd);
    cfg_en <= 1'b0;
  endtask

  task automatic set_phase(int ph);
    case (ph)
      0: configure(16'd3000, 16'd6000, 16'd7000, 16'(-20000), 16'd20000, 16'd4000);
      1: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF);
      2: configure(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      3: configure(16'($urandom_range(0, 8192)), 16'($urandom), 16'($urandom),
                   16'd12800, 16'(-12800), 16'($urandom));
      NUM_PHASES - 1: configure(16'd4096, 16'd8192, 16'd8192, 16'(-25600), 16'd25600,
                                16'd25600);
      default: configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom));
    endcase
  endtask

  // mostly well-formed sweeps; a few misplaced sweep marks and reloads
  task automatic run_phase(int count);
    int left, len;
    opcode_t op;
    logic [3:0] p;
    logic eos;
    left = count;
    while (left > 0) begin
      len = $urandom_range(1, 16);
      if (len > left) len = left;
      for (int k = 0; k < len; k++) begin
        op = ($urandom_range(0, 7) == 0) ? OP_LOAD : OP_UPDATE;
        p = 4'($urandom_range(0, SWARM_SIZE - 1));
        if (op == OP_UPDATE && !loaded[p]) op = OP_LOAD;
        eos = (k == len - 1);
        if ($urandom_range(0, 24) == 0) eos = !eos;
        send_item(make_item(op, p, eos));
      end
      left -= len;
    end
  endtask

  initial begin
    int stall;
    stall = 0;
    results_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && results_if.valid && results_if.ready) sb.check_result(results_if.data);
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        results_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        stall = $urandom_range(1, 12) - 1;
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[particle_swarm_update] ERROR");
    $finish;
  end

  initial begin
    sb = new();
    quiet = 1'b0;
    foreach (loaded[i]) loaded[i] = 1'b0;
    rst = 1'b1;
    items_if.valid = 1'b0;
    items_if.data = '0;
    cfg_en = 1'b0;
    cfg_index = CFG_INERTIA;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // seed the whole swarm: origin, corners, ties and the convergence edge
    load_at(4'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    load_at(4'd15, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 1'b0);
    load_at(4'd1, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
    load_at(4'd2, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 1'b0);
    load_at(4'd3, 16'd256, 16'd0, 16'd100, 16'(-100), 1'b0);
    load_at(4'd4, 16'd0, 16'd256, 16'(-100), 16'd100, 1'b0);
    load_at(4'd5, 16'(-255), 16'd255, 16'd0, 16'd0, 1'b0);
    load_at(4'd6, 16'(-256), 16'd100, 16'd300, 16'd0, 1'b0);
    for (int p = 7; p < SWARM_SIZE - 1; p++)
      send_item(make_item(OP_LOAD, 4'(p), p == SWARM_SIZE - 2));
    update_at(4'd0, 16'h0000, 1'b0);
    update_at(4'd15, 16'hFFFF, 1'b0);
    update_at(4'd1, 16'h8000, 1'b0);
    update_at(4'd5, 16'h0001, 1'b1);
    update_at(4'd3, 16'h0000, 1'b0);
    update_at(4'd4, 16'h0000, 1'b1);
    update_at(4'd2, 16'hFFFF, 1'b1);
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == NUM_PHASES - 1) quiet = 1'b1;
      set_phase(ph);
      run_phase(PHASE_ITEMS);
      wait_idle();
    end
    repeat (30) @(posedge clk);
    sb.flush_leftover();

    if (sb.mismatches == 0) begin
      $display("[particle_swarm_update] OK");
    end else begin
      $display("[particle_swarm_update] ERROR");
    end
    $finish;
  end

endmodule
